// File: hw/rtl/tpg_pkg.sv
package tpg_pkg;

  // coordinate and pixel widths
  localparam int unsigned CoordW = 10;
  localparam int unsigned PixelW = 8;

  // frame geometry; the frame height documents the frame only
  localparam int unsigned FrameWidth  = 1024;
  localparam int unsigned FrameHeight = 768;

  // width of the diagonal sums, enough for the 1024 pixel frame width
  localparam int unsigned SumW = 12;

  localparam logic [PixelW-1:0] White = 8'hFF;
  localparam logic [PixelW-1:0] Black = 8'h00;

  // pattern codes; odd codes of the block patterns use 128 pixel blocks
  typedef enum logic [3:0] {
    PAT_RAMP2,
    PAT_RAMP2_INV,
    PAT_RAMP4,
    PAT_RAMP4_INV,
    PAT_CHECK_S,
    PAT_CHECK_L,
    PAT_CHKDIAG_S,
    PAT_CHKDIAG_L,
    PAT_RISE_S,
    PAT_RISE_L,
    PAT_FALL_S,
    PAT_FALL_L,
    PAT_WEDGE_S,
    PAT_WEDGE_L
  } pattern_e;

  typedef struct packed {
    logic [CoordW-1:0] row;
    logic [CoordW-1:0] column;
  } coord_t;

endpackage

// File: hw/rtl/test_pattern_generator_core.sv
// Test pattern generator core. Give a pixel coordinate (row_i, column_i) with
// start_i high and the 8-bit grey value of the selected test pattern appears
// on pixel_o at the result register, marked by done_o for exactly one cycle.
// busy_o is never raised: one coordinate is taken in every clock cycle, so a
// full 1024 pixel line streams out at one pixel per clock. The path is one
// input register, a short stretch of compare and select logic, and the
// result register. The receiver cannot stall; it must take each result in
// the cycle that done_o is high. The pattern is chosen by a write on the cfg
// channel (cfg_valid_i/cfg_ready_o, always ready); write it only while no
// transaction is in flight. Codes 14 and 15 give a black pixel.
module test_pattern_generator_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // coordinate transactions
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [tpg_pkg::CoordW-1:0]    row_i,
  input  logic [tpg_pkg::CoordW-1:0]    column_i,
  // result strobe and pixel
  output logic                          done_o,
  output logic [tpg_pkg::PixelW-1:0]    pixel_o,
  // pattern select register
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [3:0]                    cfg_data_i
);
  import tpg_pkg::*;

  pattern_e            sel_q;
  coord_t              coord_q;
  logic                in_vld_q;
  logic                done_q;
  logic [PixelW-1:0]   pixel_q;
  logic [PixelW-1:0]   pixel_d;
  logic                accept;

  // never stalls: a new coordinate can enter every cycle
  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start_i && !busy_o;

  // pattern select register, reset to the double-width ramp
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q <= PAT_RAMP2;
    end else if (cfg_valid_i && cfg_ready_o) begin
      sel_q <= pattern_e'(cfg_data_i);
    end
  end

  // input stage: capture the coordinate of an accepted transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      coord_q.row    <= row_i;
      coord_q.column <= column_i;
    end
  end

  // pattern logic between the two register stages
  tpg_pattern u_pattern (
    .sel_i   (sel_q),
    .coord_i (coord_q),
    .pixel_o (pixel_d)
  );

  // result stage: one-cycle strobe with the pixel value
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_vld_q) begin
      pixel_q <= pixel_d;
    end
  end

  assign done_o  = done_q;
  assign pixel_o = pixel_q;

  // every accepted coordinate yields a result through the input and result registers
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##2 done_o)
    else $error("accepted coordinate produced no result");

  // no result without a coordinate captured in the input register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(done_o) |-> $past(in_vld_q))
    else $error("result strobe without a captured coordinate");

  // unused pattern codes give black
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (sel_q > PAT_WEDGE_L)) |-> (pixel_o == Black))
    else $error("unused pattern code gave a non-black pixel");

endmodule

// File: hw/rtl/tpg_pattern.sv
module tpg_pattern (
  input  tpg_pkg::pattern_e            sel_i,
  input  tpg_pkg::coord_t              coord_i,
  output logic [tpg_pkg::PixelW-1:0]   pixel_o
);
  import tpg_pkg::*;

  localparam logic [SumW-1:0] FallOffset = SumW'(FrameWidth - 1);

  logic                lg;
  logic                rb, cb, rise_b, fall_b;
  logic [SumW-1:0]     sum_rise, sum_fall;
  logic [CoordW-2:0]   half;
  logic [8:0]          seg;
  logic [PixelW-1:0]   ramp2, ramp2_inv, ramp4;
  logic [6:0]          ri, ci, rev;
  logic [PixelW-1:0]   wedge_px;

  always_comb begin
    lg = sel_i[0];
    rb = lg ? coord_i.row[7] : coord_i.row[6];
    cb = lg ? coord_i.column[7] : coord_i.column[6];

    sum_rise = SumW'(coord_i.row) + SumW'(coord_i.column);
    sum_fall = SumW'(coord_i.row) + FallOffset - SumW'(coord_i.column);
    rise_b   = lg ? sum_rise[7] : sum_rise[6];
    fall_b   = lg ? sum_fall[7] : sum_fall[6];

    // triangle ramps: falling half is the complement of the low byte
    half      = coord_i.column[CoordW-1:1];
    seg       = coord_i.column[8:0];
    ramp2     = half[8] ? ~half[7:0] : half[7:0];
    ramp2_inv = half[8] ? (half[7:0] + 8'd1) : ~half[7:0];
    ramp4     = seg[8] ? ~seg[7:0] : seg[7:0];

    // offsets inside a block and the mirrored row offset
    ri  = lg ? coord_i.row[6:0]    : {1'b0, coord_i.row[5:0]};
    ci  = lg ? coord_i.column[6:0] : {1'b0, coord_i.column[5:0]};
    rev = lg ? ~coord_i.row[6:0]   : {1'b0, ~coord_i.row[5:0]};

    if (!rb && !cb) begin
      wedge_px = (rev < ci) ? White : Black;
    end else if (!rb) begin
      wedge_px = (ri < ci) ? Black : White;
    end else if (!cb) begin
      wedge_px = (ri <= ci) ? White : Black;
    end else begin
      wedge_px = (rev < ci) ? Black : White;
    end

    case (sel_i)
      PAT_RAMP2:                    pixel_o = ramp2;
      PAT_RAMP2_INV:                pixel_o = ramp2_inv;
      PAT_RAMP4:                    pixel_o = ramp4;
      PAT_RAMP4_INV:                pixel_o = ~ramp4;
      PAT_CHECK_S, PAT_CHECK_L:     pixel_o = (rb ^ cb) ? Black : White;
      PAT_CHKDIAG_S, PAT_CHKDIAG_L: pixel_o = (rb ^ cb ^ rise_b) ? Black : White;
      PAT_RISE_S, PAT_RISE_L:       pixel_o = rise_b ? White : Black;
      PAT_FALL_S, PAT_FALL_L:       pixel_o = fall_b ? White : Black;
      PAT_WEDGE_S, PAT_WEDGE_L:     pixel_o = wedge_px;
      default:                      pixel_o = Black;
    endcase
  end

endmodule

// File: verif/test_pattern_generator_checker.sv
`timescale 1ns / 1ps

module test_pattern_generator_checker
  import tpg_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              busy_i,
  input  logic [CoordW-1:0] row_i,
  input  logic [CoordW-1:0] column_i,
  input  logic              done_i,
  input  logic [PixelW-1:0] pixel_i,
  input  logic              cfg_valid_i,
  input  logic              cfg_ready_i,
  input  logic [3:0]        cfg_data_i,
  output int                pending_o,
  output int                errors_o
);

  typedef struct {
    logic [3:0]        pattern;
    coord_t            coord;
    logic [PixelW-1:0] pixel;
  } expected_pixel_t;

  logic [3:0]      pattern_q;
  expected_pixel_t pixel_queue[$];
  int              fail_count;

  // stripe bit of a diagonal or block coordinate; blocks are powers of two
  function automatic logic block_bit(int unsigned v, int unsigned blk);
    return ((v / blk) % 2) != 0;
  endfunction

  function automatic logic [PixelW-1:0] wedge_pixel(int unsigned r, int unsigned c,
                                                    int unsigned blk);
    logic        qr;
    logic        qc;
    int unsigned ri;
    int unsigned ci;
    int unsigned rev;
    qr  = block_bit(r, blk);
    qc  = block_bit(c, blk);
    ri  = r % blk;
    ci  = c % blk;
    rev = (blk - 1) - ri;
    if (!qr && !qc) return (rev < ci) ? White : Black;
    if (!qr)        return (ri < ci) ? Black : White;
    if (!qc)        return (ri <= ci) ? White : Black;
    return (rev < ci) ? Black : White;
  endfunction

  function automatic logic [PixelW-1:0] pattern_pixel(logic [3:0] sel,
                                                      logic [CoordW-1:0] row,
                                                      logic [CoordW-1:0] column);
    int unsigned r;
    int unsigned c;
    int unsigned blk;
    int unsigned half;
    int unsigned seg;
    int unsigned ramp;
    logic        rb;
    logic        cb;
    logic        rise_b;
    logic        fall_b;
    r      = row;
    c      = column;
    blk    = sel[0] ? 128 : 64;
    half   = c >> 1;
    seg    = c & 511;
    ramp   = (seg < 256) ? seg : 511 - seg;
    rb     = block_bit(r, blk);
    cb     = block_bit(c, blk);
    rise_b = block_bit(r + c, blk);
    fall_b = block_bit(r + (FrameWidth - 1) - c, blk);
    case (sel)
      PAT_RAMP2:                   return PixelW'((half < 256) ? half : 511 - half);
      // last pixel pair of the line wraps to black
      PAT_RAMP2_INV:               return PixelW'((half < 256) ? 255 - half : half - 255);
      PAT_RAMP4:                   return PixelW'(ramp);
      PAT_RAMP4_INV:               return PixelW'(255 - ramp);
      PAT_CHECK_S, PAT_CHECK_L:    return (rb ^ cb) ? Black : White;
      PAT_CHKDIAG_S, PAT_CHKDIAG_L: return (rb ^ cb ^ rise_b) ? Black : White;
      PAT_RISE_S, PAT_RISE_L:      return rise_b ? White : Black;
      PAT_FALL_S, PAT_FALL_L:      return fall_b ? White : Black;
      PAT_WEDGE_S, PAT_WEDGE_L:    return wedge_pixel(r, c, blk);
      default:                     return Black;
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_q <= PAT_RAMP2;
      pixel_queue.delete();
      fail_count = 0;
      pending_o <= 0;
      errors_o  <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        pattern_q <= cfg_data_i;
      end
      if (done_i) begin
        if (pixel_queue.size() == 0) begin
          $error("pixel: expected none, actual %0d", pixel_i);
          fail_count++;
        end else if (pixel_queue[0].pixel !== pixel_i) begin
          $error("pixel: expected %0d, actual %0d (pattern %0d, row %0d, column %0d)",
                 pixel_queue[0].pixel, pixel_i, pixel_queue[0].pattern,
                 pixel_queue[0].coord.row, pixel_queue[0].coord.column);
          fail_count++;
          void'(pixel_queue.pop_front());
        end else begin
          void'(pixel_queue.pop_front());
        end
      end
      if (start_i && !busy_i) begin
        pixel_queue.push_back('{pattern: pattern_q,
                                coord:   '{row: row_i, column: column_i},
                                pixel:   pattern_pixel(pattern_q, row_i, column_i)});
      end
      pending_o <= pixel_queue.size();
      errors_o  <= fail_count;
    end
  end

endmodule

// File: verif/tb_test_pattern_generator_core.sv
`timescale 1ns / 1ps

module tb_test_pattern_generator_core;
  import tpg_pkg::*;

  localparam int unsigned NumPhases     = 22;
  localparam int unsigned ItemsPerPhase = 75;
  localparam int unsigned MaxGap        = 11;
  // settle cycles after the pipeline drains, before touching the pattern register
  localparam int unsigned SettleCycles  = 6;

  // stimulus flavors of one random phase
  typedef enum int {
    RASTER,   // consecutive pixels along lines, wrapping to the next row
    SCATTER,  // coordinates anywhere, rows past the frame now and then
    EDGES,    // coordinates next to 64 pixel block borders
    MIXED     // scatter and border coordinates interleaved
  } style_e;

  // gap behavior of the sender within one phase
  typedef enum int {
    STREAM,   // no idle cycles at all
    BURSTY,   // gap drawn 0..11 for every transaction
    SPARSE    // mostly back to back, an occasional gap
  } idle_e;

  logic              clk_i;
  logic              rst_ni;
  logic              start_i;
  logic              busy_o;
  logic [CoordW-1:0] row_i;
  logic [CoordW-1:0] column_i;
  logic              done_o;
  logic [PixelW-1:0] pixel_o;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic [3:0]        cfg_data_i;

  int pending;
  int fails;
  int coords_sent;
  int rows_past_frame;
  int pattern_writes;

  // directed corner coordinates; the first 16 go with patterns 0..15,
  // the last 8 are second points for patterns 0..7
  logic [CoordW-1:0] dir_row [24] = '{
    0, 5, 767, 0, 63, 128, 1023, 768, 63, 127, 0, 1023, 63, 128, 1023, 0,
    767, 0, 1, 1023, 64, 767, 64, 127};
  logic [CoordW-1:0] dir_col [24] = '{
    0, 1023, 255, 256, 64, 127, 0, 1023, 0, 1, 1023, 1023, 63, 128, 1023, 0,
    511, 1022, 512, 767, 1023, 0, 64, 127};

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  test_pattern_generator_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .row_i       (row_i),
    .column_i    (column_i),
    .done_o      (done_o),
    .pixel_o     (pixel_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  test_pattern_generator_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_i      (busy_o),
    .row_i       (row_i),
    .column_i    (column_i),
    .done_i      (done_o),
    .pixel_i     (pixel_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_i (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .pending_o   (pending),
    .errors_o    (fails)
  );

  // wait until every pixel in flight has come back; the first edge lets the
  // checker account for a transaction accepted in the current step
  task automatic wait_drained();
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // switch pattern, only with nothing in flight
  task automatic write_pattern(logic [3:0] sel);
    start_i <= 1'b0;
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= sel;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    pattern_writes++;
  endtask

  // one coordinate transaction; start stays high when the next gap is zero
  task automatic send_coord(logic [CoordW-1:0] row, logic [CoordW-1:0] column,
                            int unsigned gap);
    if (gap != 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i  <= 1'b1;
    row_i    <= row;
    column_i <= column;
    do @(posedge clk_i); while (busy_o);
    coords_sent++;
    if (row >= FrameHeight) rows_past_frame++;
  endtask

  // a coordinate just around a 64 pixel border; 0 - 1 wraps to 1023
  function automatic logic [CoordW-1:0] near_block_edge();
    return CoordW'($urandom_range(0, 15) * 64 + $urandom_range(0, 2) - 1);
  endfunction

  function automatic logic [CoordW-1:0] scatter_row();
    return ($urandom_range(0, 3) == 0) ? CoordW'($urandom_range(768, 1023))
                                       : CoordW'($urandom_range(0, 767));
  endfunction

  initial begin
    logic [3:0]        sel;
    logic [CoordW-1:0] row_n;
    logic [CoordW-1:0] column_n;
    style_e            style;
    idle_e             idling;
    int unsigned       draw;
    int unsigned       gap;

    rst_ni      = 1'b0;
    start_i     = 1'b0;
    row_i       = '0;
    column_i    = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = '0;
    coords_sent     = 0;
    rows_past_frame = 0;
    pattern_writes  = 0;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed corners: every selector, unused codes 14 and 15 included,
    // ramp wrap at the line end, rows past the frame, block borders
    for (int s = 0; s < 16; s++) begin
      write_pattern(4'(s));
      send_coord(dir_row[s], dir_col[s], 0);
      if (s < 8) send_coord(dir_row[16 + s], dir_col[16 + s], $urandom_range(0, 2));
    end

    // random phases: all 16 selector values in order, then random ones
    for (int p = 0; p < NumPhases; p++) begin
      sel = (p < 16) ? 4'(p) : 4'($urandom_range(0, 15));
      write_pattern(sel);
      draw     = $urandom_range(0, 4);
      style    = (draw == 4) ? RASTER : style_e'(draw);
      idling   = idle_e'($urandom_range(0, 2));
      row_n    = scatter_row();
      column_n = ($urandom_range(0, 1) == 0) ? '0 : CoordW'($urandom_range(0, 1023));

      for (int i = 0; i < ItemsPerPhase; i++) begin
        case (style)
          RASTER: begin
            if (i != 0) begin
              column_n = column_n + 1'b1;
              if (column_n == '0) row_n = row_n + 1'b1;
            end
          end
          SCATTER: begin
            row_n    = scatter_row();
            column_n = CoordW'($urandom_range(0, 1023));
          end
          EDGES: begin
            row_n    = near_block_edge();
            column_n = near_block_edge();
          end
          default: begin
            row_n    = ($urandom_range(0, 1) == 0) ? scatter_row() : near_block_edge();
            column_n = ($urandom_range(0, 1) == 0) ? CoordW'($urandom_range(0, 1023))
                                                   : near_block_edge();
          end
        endcase

        case (idling)
          STREAM:  gap = 0;
          BURSTY:  gap = $urandom_range(0, MaxGap);
          default: gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, MaxGap) : 0;
        endcase

        // hold off mid phase until the pipeline is empty, once for sure
        if ((p == 5 && i == ItemsPerPhase / 2) || $urandom_range(0, 255) == 0) begin
          start_i <= 1'b0;
          wait_drained();
        end

        send_coord(row_n, column_n, gap);
      end
    end

    start_i <= 1'b0;
    wait_drained();

    $display("tb: %0d coordinates checked over %0d pattern writes (codes 0..15)",
             coords_sent, pattern_writes);
    $display("tb: %0d of them on rows past the visible frame", rows_past_frame);
    if (fails == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #2ms;
    $display("tb: failure");
    $finish;
  end

endmodule
